>>> hw/rtl/cpt_pkg.sv
// ----------------------------------------------------------------------------
// cpt_pkg
// Shared types and constants of the camera pose tracker.
// ----------------------------------------------------------------------------
package cpt_pkg;

	localparam int YAW_FULL    = 46080;   // 360 degrees in 1/128 degree
	localparam int YAW_HALF    = 23040;
	localparam int YAW_QUARTER = 11520;
	localparam int PITCH_LIMIT = 11507;   // 89.9 degrees
	localparam int DIR_ONE     = 16384;   // 1.0 in Q2.14
	localparam int CORDIC_STEPS = 16;
	localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

	typedef enum logic [2:0] {
		KIND_SET_POS  = 3'd0,
		KIND_SET_ROT  = 3'd1,
		KIND_HOME     = 3'd2,
		KIND_MOVE_WLD = 3'd3,
		KIND_MOVE_REL = 3'd4,
		KIND_ROTATE   = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		CFG_HOME_X     = 3'd0,
		CFG_HOME_Y     = 3'd1,
		CFG_HOME_Z     = 3'd2,
		CFG_HOME_YAW   = 3'd3,
		CFG_HOME_PITCH = 3'd4
	} cfg_idx_t;

	// arctangent of 2^-i in 1/65536 degree
	function automatic logic signed [25:0] atan_f(input logic [3:0] i);
		logic signed [25:0] r;
		unique case (i)
			4'd0:  r = 26'sd2949120;
			4'd1:  r = 26'sd1740967;
			4'd2:  r = 26'sd919879;
			4'd3:  r = 26'sd466945;
			4'd4:  r = 26'sd234379;
			4'd5:  r = 26'sd117304;
			4'd6:  r = 26'sd58666;
			4'd7:  r = 26'sd29335;
			4'd8:  r = 26'sd14668;
			4'd9:  r = 26'sd7334;
			4'd10: r = 26'sd3667;
			4'd11: r = 26'sd1833;
			4'd12: r = 26'sd917;
			4'd13: r = 26'sd458;
			4'd14: r = 26'sd229;
			default: r = 26'sd115;
		endcase
		return r;
	endfunction

endpackage

>>> hw/rtl/camera_pose_tracker_unit.sv
// ----------------------------------------------------------------------------
// camera_pose_tracker_unit
// Camera pose keeper: position, yaw, pitch and view direction per command.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on in_valid/in_ready (kind, value_x/y/z). Every request
//   yields exactly one result on out_valid/out_ready with the pose after it.
//   Home pose registers are written through cfg_we/cfg_index/cfg_data; the
//   user must do so only while the block is idle, which is not enforced.
// Steps (accept to out_valid):
//   set position, world move, unused kinds: decode, output load
//   relative move: twelve products on the shared multiplier, then the
//     saturating add
//   set rotation, home, rotate: bit-serial yaw reduction with its start,
//     two 16-step CORDIC runs, direction products, decode and output load
// Requests: one at a time; in_ready is high only while idle, so a new
//   request is taken only after the previous one has finished its work.
// A result held by a stalled receiver does not block the next request; that
//   request finishes its work and then waits until the output register frees.
// Reset: pose goes to the origin with yaw and pitch zero, direction +x, and
//   all home registers to zero.
// ----------------------------------------------------------------------------
module camera_pose_tracker_unit
	import cpt_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         kind,
	input  logic signed [31:0] value_x,
	input  logic signed [31:0] value_y,
	input  logic signed [31:0] value_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] pos_z,
	output logic [15:0]        yaw_out,
	output logic signed [14:0] pitch_out,
	output logic signed [15:0] dir_x,
	output logic signed [15:0] dir_y,
	output logic signed [15:0] dir_z,
	output logic               saturated,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	typedef enum logic [2:0] {
		S_IDLE, S_DISP, S_MOD, S_PITCH, S_YAW, S_DIR, S_REL, S_APPLY
	} state_t;
	typedef enum logic [2:0] { D_T1, D_T2, D_T3, D_AX, D_AY, D_AZ } dest_t;
	typedef enum logic [1:0] { M_LOAD, M_ADD, M_SUB } mode_t;

	state_t state_q;
	logic   out_pend_q;

	logic signed [31:0] home_x_q, home_y_q, home_z_q;
	logic [15:0]        home_yaw_q;
	logic signed [14:0] home_pitch_q;

	logic [2:0]         kind_q;
	logic signed [31:0] vx_q, vy_q, vz_q;
	logic signed [31:0] px_q, py_q, pz_q;
	logic [15:0]        yaw_q;
	logic signed [14:0] pitch_q;
	logic signed [15:0] dx_q, dy_q, dz_q;
	logic               sat_q;

	logic               out_valid_q;
	logic signed [31:0] opx_q, opy_q, opz_q;
	logic [15:0]        oyaw_q;
	logic signed [14:0] opitch_q;
	logic signed [15:0] odx_q, ody_q, odz_q;
	logic               osat_q;

	logic               mod_start_q, cor_start_q;
	logic signed [33:0] mod_in_q;
	logic signed [16:0] cor_ang_q;
	logic               mod_done, cor_done;
	logic [15:0]        mod_res;
	logic signed [31:0] cor_sin, cor_cos;
	logic signed [31:0] sp_q, cp_q;

	logic [3:0]         step_q;
	logic               phase_q;
	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] prod_s1, term;
	logic signed [63:0] t1_q, t2_q, t3_q, ax_q, ay_q, az_q;
	dest_t              op_dest;
	mode_t              op_mode;
	logic               op_sh;

	logic signed [35:0] rx, ry, rz;
	logic signed [35:0] ddx, ddy, ddz;
	logic [32:0]        sx, sy, sz;
	logic signed [63:0] dir_rnd;
	logic signed [31:0] sp_rnd;

	function automatic logic signed [14:0] clamp_pitch(input logic signed [32:0] v);
		logic signed [14:0] r;
		if (v > 33'(PITCH_LIMIT))
			r = 15'(PITCH_LIMIT);
		else if (v < -33'(PITCH_LIMIT))
			r = -15'(PITCH_LIMIT);
		else
			r = v[14:0];
		return r;
	endfunction

	function automatic logic signed [15:0] clamp_dir(input logic signed [17:0] v);
		logic signed [15:0] r;
		if (v > 18'(DIR_ONE))
			r = 16'(DIR_ONE);
		else if (v < -18'(DIR_ONE))
			r = -16'(DIR_ONE);
		else
			r = v[15:0];
		return r;
	endfunction

	// {saturated flag, new component}
	function automatic logic [32:0] sat_add(input logic signed [31:0] p,
	                                        input logic signed [35:0] d);
		logic signed [36:0] s;
		logic [32:0]        r;
		s = 37'(p) + 37'(d);
		if (s > 37'sh0_7FFF_FFFF)
			r = {1'b1, 32'h7FFF_FFFF};
		else if (s < -37'sh0_8000_0000)
			r = {1'b1, 32'h8000_0000};
		else
			r = {1'b0, s[31:0]};
		return r;
	endfunction

	cpt_yaw_mod u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mod_start_q),
		.value  (mod_in_q),
		.done   (mod_done),
		.result (mod_res)
	);

	cpt_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cor_start_q),
		.angle  (cor_ang_q),
		.done   (cor_done),
		.sin_q  (cor_sin),
		.cos_q  (cor_cos)
	);

	cpt_mul u_mul (
		.clk     (clk),
		.a       (mul_a),
		.b       (mul_b),
		.prod_s1 (prod_s1)
	);

	// operand schedule for the shared multiplier
	always_comb begin
		mul_a   = 32'(dx_q);
		mul_b   = 32'(dy_q);
		op_dest = D_T1;
		op_mode = M_LOAD;
		op_sh   = 1'b0;
		if (state_q == S_DIR) begin
			mul_a = cp_q;
			mul_b = step_q[0] ? cor_sin : cor_cos;
		end else begin
			unique case (step_q)
				4'd0: begin mul_a = 32'(dx_q); mul_b = 32'(dy_q); op_dest = D_T1; end
				4'd1: begin mul_a = 32'(dy_q); mul_b = 32'(dz_q); op_dest = D_T2; end
				4'd2: begin mul_a = 32'(dx_q); mul_b = 32'(dx_q); op_dest = D_T3; end
				4'd3: begin
					mul_a = 32'(dz_q); mul_b = 32'(dz_q); op_dest = D_T3; op_mode = M_ADD;
				end
				4'd4: begin mul_a = 32'(dx_q); mul_b = vz_q; op_dest = D_AX; op_sh = 1'b1; end
				4'd5: begin
					mul_a = 32'(dz_q); mul_b = vx_q; op_dest = D_AX; op_mode = M_ADD;
					op_sh = 1'b1;
				end
				4'd6: begin mul_a = t1_q[31:0]; mul_b = vy_q; op_dest = D_AX; op_mode = M_ADD; end
				4'd7: begin mul_a = 32'(dy_q); mul_b = vz_q; op_dest = D_AY; op_sh = 1'b1; end
				4'd8: begin mul_a = t3_q[31:0]; mul_b = vy_q; op_dest = D_AY; op_mode = M_SUB; end
				4'd9: begin mul_a = 32'(dz_q); mul_b = vz_q; op_dest = D_AZ; op_sh = 1'b1; end
				4'd10: begin
					mul_a = 32'(dx_q); mul_b = vx_q; op_dest = D_AZ; op_mode = M_SUB;
					op_sh = 1'b1;
				end
				4'd11: begin mul_a = t2_q[31:0]; mul_b = vy_q; op_dest = D_AZ; op_mode = M_ADD; end
				default: begin mul_a = '0; mul_b = '0; end
			endcase
		end
	end

	assign term    = op_sh ? (prod_s1 <<< 14) : prod_s1;
	assign dir_rnd = (prod_s1 + 64'sh0000_2000_0000_0000) >>> 46;
	assign sp_rnd  = (sp_q + 32'sh0000_8000) >>> 16;

	assign rx = 36'((ax_q + 64'sh0000_0000_0800_0000) >>> 28);
	assign ry = 36'((ay_q + 64'sh0000_0000_0800_0000) >>> 28);
	assign rz = 36'((az_q + 64'sh0000_0000_0800_0000) >>> 28);

	// world move adds the request values, relative move the rounded offsets
	assign ddx = (state_q == S_APPLY) ? rx : 36'(vx_q);
	assign ddy = (state_q == S_APPLY) ? ry : 36'(vy_q);
	assign ddz = (state_q == S_APPLY) ? rz : 36'(vz_q);
	assign sx  = sat_add(px_q, ddx);
	assign sy  = sat_add(py_q, ddy);
	assign sz  = sat_add(pz_q, ddz);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			out_pend_q   <= 1'b0;
			mod_start_q  <= 1'b0;
			cor_start_q  <= 1'b0;
			out_valid_q  <= 1'b0;
			home_x_q     <= '0;
			home_y_q     <= '0;
			home_z_q     <= '0;
			home_yaw_q   <= '0;
			home_pitch_q <= '0;
			kind_q       <= '0;
			vx_q         <= '0;
			vy_q         <= '0;
			vz_q         <= '0;
			px_q         <= '0;
			py_q         <= '0;
			pz_q         <= '0;
			yaw_q        <= '0;
			pitch_q      <= '0;
			dx_q         <= 16'(DIR_ONE);
			dy_q         <= '0;
			dz_q         <= '0;
			sat_q        <= 1'b0;
			opx_q        <= '0;
			opy_q        <= '0;
			opz_q        <= '0;
			oyaw_q       <= '0;
			opitch_q     <= '0;
			odx_q        <= '0;
			ody_q        <= '0;
			odz_q        <= '0;
			osat_q       <= 1'b0;
			mod_in_q     <= '0;
			cor_ang_q    <= '0;
			sp_q         <= '0;
			cp_q         <= '0;
			step_q       <= '0;
			phase_q      <= 1'b0;
		end else begin
			mod_start_q <= 1'b0;
			cor_start_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_HOME_X:     home_x_q     <= cfg_data;
					CFG_HOME_Y:     home_y_q     <= cfg_data;
					CFG_HOME_Z:     home_z_q     <= cfg_data;
					CFG_HOME_YAW:   home_yaw_q   <= cfg_data[15:0];
					CFG_HOME_PITCH: home_pitch_q <= cfg_data[14:0];
					default: ;
				endcase
			end

			// move a finished pose into the output register once it is free
			if (out_pend_q && state_q == S_IDLE && (!out_valid_q || out_ready)) begin
				out_pend_q  <= 1'b0;
				out_valid_q <= 1'b1;
				opx_q       <= px_q;
				opy_q       <= py_q;
				opz_q       <= pz_q;
				oyaw_q      <= yaw_q;
				opitch_q    <= pitch_q;
				odx_q       <= dx_q;
				ody_q       <= dy_q;
				odz_q       <= dz_q;
				osat_q      <= sat_q;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_valid && !out_pend_q) begin
						kind_q  <= kind;
						vx_q    <= value_x;
						vy_q    <= value_y;
						vz_q    <= value_z;
						sat_q   <= 1'b0;
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					step_q  <= '0;
					phase_q <= 1'b0;
					unique case (kind_q)
						KIND_SET_POS: begin
							px_q       <= vx_q;
							py_q       <= vy_q;
							pz_q       <= vz_q;
							out_pend_q <= 1'b1;
							state_q    <= S_IDLE;
						end
						KIND_SET_ROT: begin
							pitch_q     <= clamp_pitch(33'(vy_q));
							mod_in_q    <= 34'(vx_q);
							mod_start_q <= 1'b1;
							state_q     <= S_MOD;
						end
						KIND_HOME: begin
							px_q        <= home_x_q;
							py_q        <= home_y_q;
							pz_q        <= home_z_q;
							pitch_q     <= clamp_pitch(33'(home_pitch_q));
							mod_in_q    <= 34'({1'b0, home_yaw_q});
							mod_start_q <= 1'b1;
							state_q     <= S_MOD;
						end
						KIND_MOVE_WLD: begin
							px_q       <= sx[31:0];
							py_q       <= sy[31:0];
							pz_q       <= sz[31:0];
							sat_q      <= sx[32] | sy[32] | sz[32];
							out_pend_q <= 1'b1;
							state_q    <= S_IDLE;
						end
						KIND_MOVE_REL: begin
							state_q <= S_REL;
						end
						KIND_ROTATE: begin
							pitch_q     <= clamp_pitch(33'(pitch_q) + 33'(vy_q));
							mod_in_q    <= 34'({1'b0, yaw_q}) + 34'(vx_q);
							mod_start_q <= 1'b1;
							state_q     <= S_MOD;
						end
						default: begin
							out_pend_q <= 1'b1;
							state_q    <= S_IDLE;
						end
					endcase
				end
				S_MOD: begin
					if (mod_done) begin
						yaw_q       <= mod_res;
						cor_ang_q   <= 17'(pitch_q);
						cor_start_q <= 1'b1;
						state_q     <= S_PITCH;
					end
				end
				S_PITCH: begin
					if (cor_done) begin
						sp_q        <= cor_sin;
						cp_q        <= cor_cos;
						cor_ang_q   <= 17'({1'b0, yaw_q});
						cor_start_q <= 1'b1;
						state_q     <= S_YAW;
					end
				end
				S_YAW: begin
					if (cor_done) begin
						step_q  <= '0;
						phase_q <= 1'b0;
						state_q <= S_DIR;
					end
				end
				S_DIR: begin
					phase_q <= !phase_q;
					if (phase_q) begin
						step_q <= step_q + 4'd1;
						if (step_q[0]) begin
							dz_q       <= clamp_dir(dir_rnd[17:0]);
							dy_q       <= clamp_dir(sp_rnd[17:0]);
							out_pend_q <= 1'b1;
							state_q    <= S_IDLE;
						end else begin
							dx_q <= clamp_dir(dir_rnd[17:0]);
						end
					end
				end
				S_REL: begin
					phase_q <= !phase_q;
					if (phase_q) begin
						step_q <= step_q + 4'd1;
						if (step_q == 4'd11)
							state_q <= S_APPLY;
					end
				end
				S_APPLY: begin
					px_q       <= sx[31:0];
					py_q       <= sy[31:0];
					pz_q       <= sz[31:0];
					sat_q      <= sx[32] | sy[32] | sz[32];
					out_pend_q <= 1'b1;
					state_q    <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// product accumulation for the relative move
	always_ff @(posedge clk) begin
		if (state_q == S_REL && phase_q) begin
			unique case (op_dest)
				D_T1: t1_q <= term;
				D_T2: t2_q <= term;
				D_T3: t3_q <= (op_mode == M_ADD) ? t3_q + term : term;
				D_AX: ax_q <= (op_mode == M_ADD) ? ax_q + term : term;
				D_AY: ay_q <= (op_mode == M_SUB) ? ay_q - term : term;
				D_AZ: begin
					unique case (op_mode)
						M_ADD:   az_q <= az_q + term;
						M_SUB:   az_q <= az_q - term;
						default: az_q <= term;
					endcase
				end
				default: ;
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE) && !out_pend_q;
	assign out_valid = out_valid_q;
	assign pos_x     = opx_q;
	assign pos_y     = opy_q;
	assign pos_z     = opz_q;
	assign yaw_out   = oyaw_q;
	assign pitch_out = opitch_q;
	assign dir_x     = odx_q;
	assign dir_y     = ody_q;
	assign dir_z     = odz_q;
	assign saturated = osat_q;

endmodule

>>> hw/rtl/cpt_yaw_mod.sv
// ----------------------------------------------------------------------------
// cpt_yaw_mod
// Bit-serial reduction of a signed angle modulo 360 degrees, one bit a cycle.
// ----------------------------------------------------------------------------
module cpt_yaw_mod
	import cpt_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [33:0] value,
	output logic               done,
	output logic        [15:0] result
);
	localparam int MAG_BITS = 34;
	localparam logic [16:0] MODULUS = 17'(YAW_FULL);

	logic [MAG_BITS-1:0] shift_q;
	logic [15:0]         rem_q;
	logic [5:0]          cnt_q;
	logic                busy_q, neg_q, done_q;
	logic [15:0]         result_q;
	logic [16:0]         trial;
	logic [15:0]         rem_next;

	assign trial    = {rem_q, shift_q[MAG_BITS-1]};
	assign rem_next = (trial >= MODULUS) ? 16'(trial - MODULUS) : trial[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'(MAG_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q   <= value[33];
			shift_q <= value[33] ? MAG_BITS'(-value) : MAG_BITS'(value);
			rem_q   <= '0;
		end else if (busy_q) begin
			shift_q <= {shift_q[MAG_BITS-2:0], 1'b0};
			rem_q   <= rem_next;
			if (cnt_q == 6'(MAG_BITS - 1))
				result_q <= (neg_q && rem_next != '0) ? 16'(MODULUS - {1'b0, rem_next})
				                                        : rem_next;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

>>> hw/rtl/cpt_cordic.sv
// ----------------------------------------------------------------------------
// cpt_cordic
// Iterative rotation-mode CORDIC: sine and cosine in Q30, one step a cycle.
// ----------------------------------------------------------------------------
module cpt_cordic
	import cpt_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [16:0] angle,
	output logic               done,
	output logic signed [31:0] sin_q,
	output logic signed [31:0] cos_q
);
	logic signed [33:0] x_q, y_q, x_next, y_next;
	logic signed [25:0] z_q, z_next, z0;
	logic [3:0]         cnt_q;
	logic               busy_q, neg_q, done_q, neg0;
	logic signed [17:0] a1, a2;

	// bring the angle into +-90 degrees, negating both results when shifted
	always_comb begin
		a1   = {angle[16], angle};
		a2   = a1;
		neg0 = 1'b0;
		if (a1 > 18'sd23040)
			a1 = a1 - 18'sd46080;
		a2 = a1;
		if (a1 > 18'sd11520) begin
			a2   = a1 - 18'sd23040;
			neg0 = 1'b1;
		end else if (a1 < -18'sd11520) begin
			a2   = a1 + 18'sd23040;
			neg0 = 1'b1;
		end
		z0 = 26'(a2) <<< 9;
	end

	always_comb begin
		if (!z_q[25]) begin
			x_next = x_q - (y_q >>> cnt_q);
			y_next = y_q + (x_q >>> cnt_q);
			z_next = z_q - atan_f(cnt_q);
		end else begin
			x_next = x_q + (y_q >>> cnt_q);
			y_next = y_q - (x_q >>> cnt_q);
			z_next = z_q + atan_f(cnt_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 4'd1;
				if (cnt_q == 4'(CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= CORDIC_GAIN_Q30;
			y_q   <= '0;
			z_q   <= z0;
			neg_q <= neg0;
		end else if (busy_q) begin
			x_q <= x_next;
			y_q <= y_next;
			z_q <= z_next;
			if (cnt_q == 4'(CORDIC_STEPS - 1)) begin
				sin_q <= neg_q ? 32'(-y_next) : 32'(y_next);
				cos_q <= neg_q ? 32'(-x_next) : 32'(x_next);
			end
		end
	end

	assign done = done_q;

endmodule

>>> hw/rtl/cpt_mul.sv
// ----------------------------------------------------------------------------
// cpt_mul
// Shared signed 32x32 multiplier with a registered product.
// ----------------------------------------------------------------------------
module cpt_mul
	import cpt_pkg::*;
(
	input  logic               clk,
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	output logic signed [63:0] prod_s1
);
	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
	end
endmodule

>>> hw/rtl/cpt_checker.sv
// ----------------------------------------------------------------------------
// cpt_checker
// Port-level checks of the camera pose tracker, bound to the top level.
// ----------------------------------------------------------------------------
module cpt_checker
	import cpt_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] pos_x,
	input logic [15:0]        yaw_out,
	input logic signed [14:0] pitch_out
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(pos_x) && $stable(yaw_out))
		else $error("result changed while stalled");

	a_yaw_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> yaw_out < 16'(YAW_FULL))
		else $error("yaw not wrapped");

	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pitch_out <= 15'(PITCH_LIMIT)) && (pitch_out >= -15'(PITCH_LIMIT)))
		else $error("pitch not clamped");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second request taken while busy");
endmodule

bind camera_pose_tracker_unit cpt_checker u_cpt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.pos_x     (pos_x),
	.yaw_out   (yaw_out),
	.pitch_out (pitch_out)
);

>>> verif/camera_pose_tracker_unit_tb.sv
// ----------------------------------------------------------------------------
// camera_pose_tracker_unit_tb
// Self-checking bench for the camera pose tracker. Commands go in through a
// queue-fed driver; an in-bench pose model predicts every result, and a
// monitor compares each returned pose field by field, in order.
// ----------------------------------------------------------------------------
module camera_pose_tracker_unit_tb;
	import cpt_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [2:0]         kind;
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic signed [31:0] vz;
	} cmd_t;

	typedef struct {
		logic signed [31:0] px, py, pz;
		logic [15:0]        yaw;
		logic signed [14:0] pitch;
		logic signed [15:0] dx, dy, dz;
		logic               sat;
	} pose_t;

	localparam int WATCHDOG_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] kind = '0;
	logic signed [31:0] value_x = '0, value_y = '0, value_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] pos_x, pos_y, pos_z;
	logic [15:0] yaw_out;
	logic signed [14:0] pitch_out;
	logic signed [15:0] dir_x, dir_y, dir_z;
	logic saturated;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	camera_pose_tracker_unit dut (.*);

	always #5 clk = ~clk;

	// pose model state
	longint home_pos[3];
	longint home_yaw_r, home_pitch_r;
	longint cur_pos[3];
	longint cur_yaw, cur_pitch;
	longint cur_dir[3];

	cmd_t  pending_cmds[$];
	pose_t expected_poses[$];
	int    send_idle_pct = 0;
	int    recv_stall_pct = 0;
	bit    send_hold = 0;
	bit    failed = 0;
	int    quiet_cycles = 0;

	function automatic longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint round_half_up(longint v, int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic longint wrap_angle(longint v);
		longint r;
		r = v % YAW_FULL;
		if (r < 0) r += YAW_FULL;
		return r;
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint atan_step(int i);
		longint t[16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
			58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};
		return t[i];
	endfunction

	// sine/cosine in Q30 of an angle in 1/128 degree
	task automatic cordic_sincos(input longint a, output longint s, output longint c);
		bit flip;
		longint x, y, z, nx;
		flip = 0;
		x = CORDIC_GAIN_Q30;
		y = 0;
		a = wrap_angle(a);
		if (a > YAW_HALF) a -= YAW_FULL;
		if (a > YAW_QUARTER) begin
			a -= YAW_HALF;
			flip = 1;
		end else if (a < -YAW_QUARTER) begin
			a += YAW_HALF;
			flip = 1;
		end
		z = a * 512;
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			if (z >= 0) begin
				nx = x - floor_shift(y, i);
				y = y + floor_shift(x, i);
				z -= atan_step(i);
			end else begin
				nx = x + floor_shift(y, i);
				y = y - floor_shift(x, i);
				z += atan_step(i);
			end
			x = nx;
		end
		s = flip ? -y : y;
		c = flip ? -x : x;
	endtask

	task automatic refresh_direction();
		longint sp, cp, sy, cy;
		cur_pitch = clip(cur_pitch, -PITCH_LIMIT, PITCH_LIMIT);
		cordic_sincos(cur_pitch, sp, cp);
		cordic_sincos(cur_yaw, sy, cy);
		cur_dir[0] = clip(round_half_up(cp * cy, 46), -DIR_ONE, DIR_ONE);
		cur_dir[1] = clip(round_half_up(sp, 16), -DIR_ONE, DIR_ONE);
		cur_dir[2] = clip(round_half_up(cp * sy, 46), -DIR_ONE, DIR_ONE);
	endtask

	function automatic bit add_saturating(int k, longint delta);
		longint v;
		v = cur_pos[k] + delta;
		if (v > 64'sd2147483647) begin
			cur_pos[k] = 64'sd2147483647;
			return 1;
		end
		if (v < -64'sd2147483648) begin
			cur_pos[k] = -64'sd2147483648;
			return 1;
		end
		cur_pos[k] = v;
		return 0;
	endfunction

	task automatic predict_pose(input cmd_t c);
		pose_t p;
		bit sat;
		longint vx, vy, vz, dx, dy, dz, ox, oy, oz;
		sat = 0;
		vx = c.vx;
		vy = c.vy;
		vz = c.vz;
		case (c.kind)
			KIND_SET_POS: begin
				cur_pos[0] = vx;
				cur_pos[1] = vy;
				cur_pos[2] = vz;
			end
			KIND_SET_ROT: begin
				cur_yaw = wrap_angle(vx);
				cur_pitch = vy;
				refresh_direction();
			end
			KIND_HOME: begin
				cur_pos = home_pos;
				cur_yaw = wrap_angle(home_yaw_r);
				cur_pitch = home_pitch_r;
				refresh_direction();
			end
			KIND_MOVE_WLD: begin
				sat |= add_saturating(0, vx);
				sat |= add_saturating(1, vy);
				sat |= add_saturating(2, vz);
			end
			KIND_MOVE_REL: begin
				dx = cur_dir[0];
				dy = cur_dir[1];
				dz = cur_dir[2];
				ox = (dx * vz + dz * vx) * 16384 + (dx * dy) * vy;
				oy = (dy * vz) * 16384 - (dx * dx + dz * dz) * vy;
				oz = (dz * vz - dx * vx) * 16384 + (dy * dz) * vy;
				sat |= add_saturating(0, round_half_up(ox, 28));
				sat |= add_saturating(1, round_half_up(oy, 28));
				sat |= add_saturating(2, round_half_up(oz, 28));
			end
			KIND_ROTATE: begin
				cur_yaw = wrap_angle(cur_yaw + vx);
				cur_pitch = cur_pitch + vy;
				refresh_direction();
			end
			default: ;
		endcase
		p.px = 32'(cur_pos[0]);
		p.py = 32'(cur_pos[1]);
		p.pz = 32'(cur_pos[2]);
		p.yaw = cur_yaw[15:0];
		p.pitch = cur_pitch[14:0];
		p.dx = cur_dir[0][15:0];
		p.dy = cur_dir[1][15:0];
		p.dz = cur_dir[2][15:0];
		p.sat = sat;
		expected_poses.push_back(p);
	endtask

	// driver
	always @(posedge clk) begin
		if (!in_valid || in_ready) begin
			if (pending_cmds.size() > 0 && !send_hold && arst_n &&
					$urandom_range(99) >= send_idle_pct) begin
				cmd_t c;
				c = pending_cmds.pop_front();
				predict_pose(c);
				in_valid <= 1'b1;
				kind <= c.kind;
				value_x <= c.vx;
				value_y <= c.vy;
				value_z <= c.vz;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		pose_t e;
		if (out_valid && out_ready) begin
			if (expected_poses.size() == 0) begin
				$display("%0t: unexpected result pos=(%0d,%0d,%0d)", $time,
					pos_x, pos_y, pos_z);
				failed = 1;
			end else begin
				e = expected_poses.pop_front();
				if ({pos_x, pos_y, pos_z} !== {e.px, e.py, e.pz})
					begin
					$display("%0t: pos exp (%0d,%0d,%0d) got (%0d,%0d,%0d)", $time,
						e.px, e.py, e.pz, pos_x, pos_y, pos_z);
					failed = 1;
				end
				if (yaw_out !== e.yaw || pitch_out !== e.pitch) begin
					$display("%0t: angles exp (%0d,%0d) got (%0d,%0d)", $time,
						e.yaw, e.pitch, yaw_out, pitch_out);
					failed = 1;
				end
				if ({dir_x, dir_y, dir_z} !== {e.dx, e.dy, e.dz}) begin
					$display("%0t: dir exp (%0d,%0d,%0d) got (%0d,%0d,%0d)", $time,
						e.dx, e.dy, e.dz, dir_x, dir_y, dir_z);
					failed = 1;
				end
				if (saturated !== e.sat) begin
					$display("%0t: saturated exp %0b got %0b", $time, e.sat, saturated);
					failed = 1;
				end
			end
		end
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// watchdog
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else if (arst_n)
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic logic signed [31:0] rand_value();
		case ($urandom_range(5))
			0: return 32'sh7FFFFFFF;
			1: return 32'sh80000000;
			2: return $urandom;
			default: return $signed($urandom_range(65536 * 64)) - 32'sd2097152;
		endcase
	endfunction

	function automatic logic signed [31:0] rand_angle();
		case ($urandom_range(4))
			0: return $urandom;
			1: return $signed($urandom_range(2 * YAW_FULL)) - YAW_FULL;
			default: return $signed($urandom_range(4000)) - 2000;
		endcase
	endfunction

	task automatic queue_cmd(input logic [2:0] k, input logic signed [31:0] x,
			input logic signed [31:0] y, input logic signed [31:0] z);
		cmd_t c;
		c.kind = k;
		c.vx = x;
		c.vy = y;
		c.vz = z;
		pending_cmds.push_back(c);
	endtask

	task automatic queue_random(int n);
		logic [2:0] k;
		for (int i = 0; i < n; i++) begin
			k = 3'($urandom_range(7));
			if (k == KIND_SET_ROT || k == KIND_ROTATE)
				queue_cmd(k, rand_angle(), rand_angle(), rand_value());
			else
				queue_cmd(k, rand_value(), rand_value(), rand_value());
		end
	endtask

	task automatic wait_drained();
		while (pending_cmds.size() > 0 || in_valid || expected_poses.size() > 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	// holds the write enable; the caller drops it after the last register
	task automatic write_home(input cfg_idx_t idx, input logic [31:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			CFG_HOME_X: home_pos[0] = $signed(data);
			CFG_HOME_Y: home_pos[1] = $signed(data);
			CFG_HOME_Z: home_pos[2] = $signed(data);
			CFG_HOME_YAW: home_yaw_r = data[15:0];
			default: home_pitch_r = $signed(data[14:0]);
		endcase
		@(posedge clk);
	endtask

	task automatic write_all_home(input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z, input logic [31:0] yw, input logic [31:0] p);
		write_home(CFG_HOME_X, x);
		write_home(CFG_HOME_Y, y);
		write_home(CFG_HOME_Z, z);
		write_home(CFG_HOME_YAW, yw);
		write_home(CFG_HOME_PITCH, p);
		cfg_we <= 1'b0;
	endtask

	initial begin
		home_pos = '{0, 0, 0};
		home_yaw_r = 0;
		home_pitch_r = 0;
		cur_pos = '{0, 0, 0};
		cur_yaw = 0;
		cur_pitch = 0;
		cur_dir = '{DIR_ONE, 0, 0};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every kind, field extremes, clamps and wraps
		queue_cmd(KIND_HOME, 0, 0, 0);
		queue_cmd(KIND_MOVE_REL, 32'sh10000, 32'sh10000, 32'sh10000);
		queue_cmd(KIND_SET_POS, 32'sh7FFFFFFF, 32'sh80000000, -1);
		queue_cmd(KIND_MOVE_WLD, 1, -1, 32'sh80000000);
		queue_cmd(KIND_MOVE_WLD, 32'sh80000000, 32'sh7FFFFFFF, 0);
		queue_cmd(KIND_SET_ROT, 46079, 11507, 0);
		queue_cmd(KIND_SET_ROT, 46080, -11507, 0);
		queue_cmd(KIND_SET_ROT, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0);
		queue_cmd(KIND_SET_ROT, 32'sh80000000, 32'sh80000000, 0);
		queue_cmd(KIND_SET_ROT, 23040, 0, 0);
		queue_cmd(KIND_SET_ROT, 11520, 11520, 0);
		queue_cmd(KIND_SET_ROT, -11521, 5000, 0);
		queue_cmd(KIND_ROTATE, 32'sh7FFFFFFF, 20000, 0);
		queue_cmd(KIND_ROTATE, -1, -40000, 0);
		queue_cmd(KIND_MOVE_REL, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
		queue_cmd(KIND_MOVE_REL, 32'sh80000000, 32'sh80000000, 32'sh80000000);
		queue_cmd(KIND_SET_ROT, 5760, 2000, 0);
		queue_cmd(KIND_MOVE_REL, 32'sh30000, -32'sh20000, 32'sh50000);
		queue_cmd(3'd6, 5, 5, 5);
		queue_cmd(3'd7, -1, -1, -1);
		wait_drained();

		write_all_home(32'h7FFFFFFF, 32'h80000000, 32'h12345678, 46079, 32'h0000_3FFF);
		queue_cmd(KIND_HOME, 0, 0, 0);
		queue_cmd(KIND_MOVE_WLD, 1, -1, 0);
		queue_cmd(KIND_MOVE_REL, 32'sh10000, 0, 32'sh10000);
		queue_random(380);
		wait_drained();

		write_all_home(32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'h0000_FFFF,
			32'h0000_4000);
		queue_cmd(KIND_HOME, 0, 0, 0);
		send_idle_pct = 59;
		queue_random(380);
		wait_drained();

		// sender holds with commands queued and the pipe empty, then resumes
		send_hold = 1;
		queue_random(10);
		repeat (200) @(posedge clk);
		send_hold = 0;
		wait_drained();

		write_all_home($urandom, $urandom, $urandom, $urandom_range(46079),
			$urandom_range(2 * PITCH_LIMIT) - PITCH_LIMIT);
		queue_cmd(KIND_HOME, 0, 0, 0);
		send_idle_pct = 0;
		recv_stall_pct = 59;
		queue_random(380);
		wait_drained();

		write_all_home(0, 0, 0, 0, 0);
		queue_cmd(KIND_HOME, 0, 0, 0);
		send_idle_pct = 8;
		recv_stall_pct = 8;
		queue_random(380);
		wait_drained();

		if (failed)
			$display("Simulation FAILED");
		else
			$display("Simulation PASSED");
		$finish;
	end

endmodule

>>> files.f
hw/rtl/cpt_pkg.sv
hw/rtl/cpt_yaw_mod.sv
hw/rtl/cpt_cordic.sv
hw/rtl/cpt_mul.sv
hw/rtl/camera_pose_tracker_unit.sv
hw/rtl/cpt_checker.sv
verif/camera_pose_tracker_unit_tb.sv
